### hdl/tlvni_pkg.sv
package tlvni_pkg;

    localparam int ORDER_W     = 4;
    localparam int KIND_W      = 2;
    localparam int NODE_W      = 12;
    localparam int POS_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int BASE_W      = ORDER_W + 1;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int QUOT_W      = NODE_W - 1;
    localparam int KDIG_W      = NODE_W - 2;
    localparam int CALC_W      = POS_W + 1;

    localparam int MAX_ORDER_DEF = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_KIND = 2'd1;

    // geometry kinds
    localparam logic [KIND_W-1:0] KIND_POINT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUAD    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HEX     = 2'd3;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd1;
    localparam logic [KIND_W-1:0]  KIND_RESET  = KIND_HEX;

    // node request entering the digit split
    typedef struct packed {
        logic                valid;
        logic [NODE_W-1:0]   node;
        logic [ORDER_W-1:0]  p;
        logic [KIND_W-1:0]   kind;
    } t_req;

    // digits of one node, leaving the digit split
    typedef struct packed {
        logic                valid;
        logic [ORDER_W-1:0]  p;
        logic [KIND_W-1:0]   kind;
        logic [ORDER_W-1:0]  i;
        logic [ORDER_W-1:0]  j;
        logic [ORDER_W-1:0]  k;
        logic                oor;
    } t_digits;

    // ceil(2^16 / n) for n = 2..16; exact floor division for any 12-bit dividend
    function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            5'd2:    r = 16'd32768;
            5'd3:    r = 16'd21846;
            5'd4:    r = 16'd16384;
            5'd5:    r = 16'd13108;
            5'd6:    r = 16'd10923;
            5'd7:    r = 16'd9363;
            5'd8:    r = 16'd8192;
            5'd9:    r = 16'd7282;
            5'd10:   r = 16'd6554;
            5'd11:   r = 16'd5958;
            5'd12:   r = 16'd5462;
            5'd13:   r = 16'd5042;
            5'd14:   r = 16'd4682;
            5'd15:   r = 16'd4370;
            5'd16:   r = 16'd4096;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/tlvni_split.sv
module tlvni_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlvni_pkg::t_req      i_req,
    output tlvni_pkg::t_digits   o_dig
);

    localparam int NODE_W  = tlvni_pkg::NODE_W;
    localparam int ORDER_W = tlvni_pkg::ORDER_W;
    localparam int KIND_W  = tlvni_pkg::KIND_W;
    localparam int BASE_W  = tlvni_pkg::BASE_W;
    localparam int RECIP_W = tlvni_pkg::RECIP_W;
    localparam int SH      = tlvni_pkg::RECIP_SHIFT;
    localparam int QUOT_W  = tlvni_pkg::QUOT_W;
    localparam int KDIG_W  = tlvni_pkg::KDIG_W;
    localparam int PB_W    = NODE_W + RECIP_W;
    localparam int PC_W    = QUOT_W + RECIP_W;

    // stage A: captured request with its reciprocal
    logic                 r_a_valid;
    logic [NODE_W-1:0]    r_a_node;
    logic [ORDER_W-1:0]   r_a_p;
    logic [KIND_W-1:0]    r_a_kind;
    logic [RECIP_W-1:0]   r_a_recip;

    // stage B: first quotient node / n
    logic                 r_b_valid;
    logic [NODE_W-1:0]    r_b_node;
    logic [ORDER_W-1:0]   r_b_p;
    logic [KIND_W-1:0]    r_b_kind;
    logic [RECIP_W-1:0]   r_b_recip;
    logic [QUOT_W-1:0]    r_b_q;

    // stage C: i digit and second quotient
    logic                 r_c_valid;
    logic [NODE_W-1:0]    r_c_node;
    logic [ORDER_W-1:0]   r_c_p;
    logic [KIND_W-1:0]    r_c_kind;
    logic [QUOT_W-1:0]    r_c_q;
    logic [ORDER_W-1:0]   r_c_i;
    logic [KDIG_W-1:0]    r_c_k;

    // stage D: output digits
    logic                 r_d_valid;
    logic [ORDER_W-1:0]   r_d_p;
    logic [KIND_W-1:0]    r_d_kind;
    logic [ORDER_W-1:0]   r_d_i;
    logic [ORDER_W-1:0]   r_d_j;
    logic [ORDER_W-1:0]   r_d_k;
    logic                 r_d_oor;

    logic [BASE_W-1:0]    n_a_base;
    logic [PB_W-1:0]      n_b_prod;
    logic [PC_W-1:0]      n_c_prod;
    logic [NODE_W-1:0]    n_c_qn;
    logic [NODE_W-1:0]    n_c_rem;
    logic [BASE_W-1:0]    n_c_base;
    logic [BASE_W-1:0]    n_d_base;
    logic [QUOT_W-1:0]    n_d_kn;
    logic [QUOT_W-1:0]    n_d_jhex;
    logic [ORDER_W-1:0]   n_d_j;
    logic                 n_d_oor;

    // reciprocal lookup on the incoming base
    assign n_a_base = BASE_W'(i_req.p) + BASE_W'(1);

    // quotient by reciprocal multiply
    assign n_b_prod = PB_W'(r_a_node) * PB_W'(r_a_recip);

    // remainder and quotient of the quotient
    assign n_c_base = BASE_W'(r_b_p) + BASE_W'(1);
    assign n_c_qn   = NODE_W'(r_b_q) * NODE_W'(n_c_base);
    assign n_c_rem  = r_b_node - n_c_qn;
    assign n_c_prod = PC_W'(r_b_q) * PC_W'(r_b_recip);

    // j digit and node count check
    assign n_d_base = BASE_W'(r_c_p) + BASE_W'(1);
    assign n_d_kn   = QUOT_W'(r_c_k) * QUOT_W'(n_d_base);
    assign n_d_jhex = r_c_q - n_d_kn;

    always_comb begin
        n_d_j   = n_d_jhex[ORDER_W-1:0];
        n_d_oor = 1'b0;
        case (r_c_kind)
            tlvni_pkg::KIND_POINT: begin
                n_d_oor = (r_c_node != '0);
            end
            tlvni_pkg::KIND_SEGMENT: begin
                n_d_oor = (r_c_q != '0);
            end
            tlvni_pkg::KIND_QUAD: begin
                n_d_j   = r_c_q[ORDER_W-1:0];
                n_d_oor = (r_c_q >= QUOT_W'(n_d_base));
            end
            default: begin
                n_d_oor = (r_c_k >= KDIG_W'(n_d_base));
            end
        endcase
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_req.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_a_node  <= i_req.node;
        r_a_p     <= i_req.p;
        r_a_kind  <= i_req.kind;
        r_a_recip <= tlvni_pkg::recip(n_a_base);

        r_b_node  <= r_a_node;
        r_b_p     <= r_a_p;
        r_b_kind  <= r_a_kind;
        r_b_recip <= r_a_recip;
        r_b_q     <= n_b_prod[SH+QUOT_W-1:SH];

        r_c_node  <= r_b_node;
        r_c_p     <= r_b_p;
        r_c_kind  <= r_b_kind;
        r_c_q     <= r_b_q;
        r_c_i     <= n_c_rem[ORDER_W-1:0];
        r_c_k     <= n_c_prod[SH+KDIG_W-1:SH];

        r_d_p     <= r_c_p;
        r_d_kind  <= r_c_kind;
        r_d_i     <= r_c_i;
        r_d_j     <= n_d_j;
        r_d_k     <= r_c_k[ORDER_W-1:0];
        r_d_oor   <= n_d_oor;
    end

    assign o_dig = '{valid: r_d_valid, p: r_d_p, kind: r_d_kind, i: r_d_i,
                     j: r_d_j, k: r_d_k, oor: r_d_oor};

endmodule

### hdl/tensor_lagrange_vtk_node_index.sv
// Lexicographic to VTK node position for Lagrange point, segment, quad and hex
// elements of order element_order (clamped to 1..MAX_ORDER).
//
// Request channel: drive the node number on i_node_number and raise start. A
// request is taken at every rising edge where start is high and busy is low;
// busy is always low, so one request per cycle is taken with no gaps.
// Result channel: o_vtk_position and o_out_of_range hold for exactly one cycle
// while o_strobe is high. Results leave in request order. The receiver cannot
// hold off results, and none is needed: the six register stages (reciprocal
// lookup, two reciprocal-multiply quotients, digit fix-up, offset products,
// final sum) never stall.
// Config channel: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready is
// always high. Index 0 writes element_order, index 1 writes geometry_kind,
// others are dropped. Write only while no result is pending.
// Reset (synchronous, active low) empties the pipeline and restores order 1
// and hexahedron geometry.
module tensor_lagrange_vtk_node_index #(
    parameter int MAX_ORDER = tlvni_pkg::MAX_ORDER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tlvni_pkg::NODE_W-1:0]        i_node_number,
    output logic                                o_strobe,
    output logic [tlvni_pkg::POS_W-1:0]         o_vtk_position,
    output logic                                o_out_of_range,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tlvni_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tlvni_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ORDER_W = tlvni_pkg::ORDER_W;
    localparam int KIND_W  = tlvni_pkg::KIND_W;
    localparam int POS_W   = tlvni_pkg::POS_W;
    localparam int CW      = tlvni_pkg::CALC_W;
    localparam int PM_W    = 2 * ORDER_W;
    localparam int PG_W    = 3 * ORDER_W;

    logic [ORDER_W-1:0]   r_element_order;
    logic [KIND_W-1:0]    r_geometry_kind;
    logic [ORDER_W-1:0]   n_p;

    tlvni_pkg::t_req      n_req;
    tlvni_pkg::t_digits   w_dig;

    // stage E: offset products and boundary flags
    logic                 r_e_valid;
    logic [ORDER_W-1:0]   r_e_p;
    logic [ORDER_W-1:0]   r_e_m;
    logic [KIND_W-1:0]    r_e_kind;
    logic [ORDER_W-1:0]   r_e_i;
    logic [ORDER_W-1:0]   r_e_j;
    logic [ORDER_W-1:0]   r_e_k;
    logic                 r_e_oor;
    logic                 r_e_ib;
    logic                 r_e_jb;
    logic                 r_e_kb;
    logic [PM_W-1:0]      r_e_mk;
    logic [PM_W-1:0]      r_e_mj;
    logic [PM_W-1:0]      r_e_f;

    // output registers
    logic                 r_o_strobe;
    logic [POS_W-1:0]     r_o_pos;
    logic                 r_o_oor;

    logic [ORDER_W-1:0]   n_e_m;
    logic [ORDER_W-1:0]   n_e_km1;
    logic [ORDER_W-1:0]   n_e_jm1;
    logic [PG_W-1:0]      n_g;
    logic [CW-1:0]        n_pos;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_order <= tlvni_pkg::ORDER_RESET;
            r_geometry_kind <= tlvni_pkg::KIND_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlvni_pkg::REG_ELEMENT_ORDER: r_element_order <= i_cfg_data[ORDER_W-1:0];
                tlvni_pkg::REG_GEOMETRY_KIND: r_geometry_kind <= i_cfg_data[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // clamp order into 1..MAX_ORDER
    always_comb begin
        n_p = r_element_order;
        if (n_p == '0) begin
            n_p = ORDER_W'(1);
        end
        if (int'(n_p) > MAX_ORDER) begin
            n_p = ORDER_W'(MAX_ORDER);
        end
    end

    assign n_req.valid = start && !busy;
    assign n_req.node  = i_node_number;
    assign n_req.p     = n_p;
    assign n_req.kind  = r_geometry_kind;

    tlvni_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_dig   (w_dig)
    );

    // interior offsets m*(k-1), m*(j-1) and face size m*m
    assign n_e_m   = w_dig.p - ORDER_W'(1);
    assign n_e_km1 = w_dig.k - ORDER_W'(1);
    assign n_e_jm1 = w_dig.j - ORDER_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= w_dig.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_p    <= w_dig.p;
        r_e_m    <= n_e_m;
        r_e_kind <= w_dig.kind;
        r_e_i    <= w_dig.i;
        r_e_j    <= w_dig.j;
        r_e_k    <= w_dig.k;
        r_e_oor  <= w_dig.oor;
        r_e_ib   <= (w_dig.i == '0) || (w_dig.i == w_dig.p);
        r_e_jb   <= (w_dig.j == '0) || (w_dig.j == w_dig.p);
        r_e_kb   <= (w_dig.k == '0) || (w_dig.k == w_dig.p);
        r_e_mk   <= PM_W'(n_e_m) * PM_W'(n_e_km1);
        r_e_mj   <= PM_W'(n_e_m) * PM_W'(n_e_jm1);
        r_e_f    <= PM_W'(n_e_m) * PM_W'(n_e_m);
    end

    // final position by node class
    assign n_g = PG_W'(r_e_f) * PG_W'(r_e_k - ORDER_W'(1));

    always_comb begin
        logic [CW-1:0] m;
        logic [CW-1:0] f;
        logic [CW-1:0] im1;
        logic [CW-1:0] jm1;
        logic [CW-1:0] km1;
        logic [CW-1:0] corner;
        logic [CW-1:0] jsel;
        logic [CW-1:0] isel;
        logic [CW-1:0] ksel;
        logic [CW-1:0] base1;
        logic [1:0]    nb;
        logic          inz;
        logic          jnz;
        logic          knz;

        m     = CW'(r_e_m);
        f     = CW'(r_e_f);
        im1   = CW'(r_e_i) - CW'(1);
        jm1   = CW'(r_e_j) - CW'(1);
        km1   = CW'(r_e_k) - CW'(1);
        inz   = (r_e_i != '0);
        jnz   = (r_e_j != '0);
        knz   = (r_e_k != '0);
        corner = inz ? (jnz ? CW'(2) : CW'(1)) : (jnz ? CW'(3) : CW'(0));
        jsel  = jnz ? CW'(2) * m : '0;
        isel  = inz ? m : CW'(3) * m;
        ksel  = knz ? CW'(4) * m : '0;
        base1 = CW'(8) + CW'(12) * m;
        nb    = 2'(r_e_ib) + 2'(r_e_jb) + 2'(r_e_kb);
        n_pos = '0;

        case (r_e_kind)
            tlvni_pkg::KIND_POINT: begin
                n_pos = '0;
            end
            tlvni_pkg::KIND_SEGMENT: begin
                if (r_e_i == '0) begin
                    n_pos = '0;
                end else if (r_e_i == r_e_p) begin
                    n_pos = CW'(1);
                end else begin
                    n_pos = CW'(r_e_i) + CW'(1);
                end
            end
            tlvni_pkg::KIND_QUAD: begin
                if (r_e_ib && r_e_jb) begin
                    n_pos = corner;
                end else if (r_e_jb) begin
                    n_pos = CW'(4) + im1 + jsel;
                end else if (r_e_ib) begin
                    n_pos = CW'(4) + jm1 + isel;
                end else begin
                    n_pos = CW'(4) + CW'(4) * m + im1 + CW'(r_e_mj);
                end
            end
            default: begin
                case (nb)
                    2'd3: begin
                        n_pos = corner + (knz ? CW'(4) : CW'(0));
                    end
                    2'd2: begin
                        if (!r_e_ib) begin
                            n_pos = CW'(8) + im1 + jsel + ksel;
                        end else if (!r_e_jb) begin
                            n_pos = CW'(8) + jm1 + isel + ksel;
                        end else begin
                            n_pos = CW'(8) + CW'(8) * m + km1
                                  + m * (inz ? (jnz ? CW'(3) : CW'(1))
                                             : (jnz ? CW'(2) : CW'(0)));
                        end
                    end
                    2'd1: begin
                        if (r_e_ib) begin
                            n_pos = base1 + jm1 + CW'(r_e_mk) + (inz ? f : '0);
                        end else if (r_e_jb) begin
                            n_pos = base1 + CW'(2) * f + im1 + CW'(r_e_mk)
                                  + (jnz ? f : '0);
                        end else begin
                            n_pos = base1 + CW'(4) * f + im1 + CW'(r_e_mj)
                                  + (knz ? f : '0);
                        end
                    end
                    default: begin
                        n_pos = base1 + CW'(6) * f + im1 + CW'(r_e_mj) + CW'(n_g);
                    end
                endcase
            end
        endcase
    end

    // register results; out-of-range nodes report position zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_oor <= r_e_oor;
        r_o_pos <= r_e_oor ? '0 : n_pos[POS_W-1:0];
    end

    assign o_strobe       = r_o_strobe;
    assign o_vtk_position = r_o_pos;
    assign o_out_of_range = r_o_oor;

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvni_pkg::*;

    localparam int MAX_ORDER       = MAX_ORDER_DEF;
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int PHASE_NODES     = 560;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             oor;
    } t_vtk_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [NODE_W-1:0]     i_node_number;
    logic                  o_strobe;
    logic [POS_W-1:0]      o_vtk_position;
    logic                  o_out_of_range;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_vtk_result           expected_vtk_q[$];
    logic [ORDER_W-1:0]    shadow_order;
    logic [KIND_W-1:0]     shadow_kind;
    int                    mismatch_count;
    int                    sender_idle_pct;
    int                    quiet_cycles;

    tensor_lagrange_vtk_node_index DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_node_number  (i_node_number),
        .o_strobe       (o_strobe),
        .o_vtk_position (o_vtk_position),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Map one lexicographic node number to its VTK position
    function automatic t_vtk_result map_node_to_vtk(input logic [NODE_W-1:0] node,
                                                    input logic [ORDER_W-1:0] order_reg,
                                                    input logic [KIND_W-1:0] kind_reg);
        t_vtk_result res;
        int unsigned p, n, cnt, pos, i, j, k, m, f, nb, base;
        bit          ib, jb, kb;
        p = order_reg;
        if (p < 1) p = 1;
        if (p > MAX_ORDER) p = MAX_ORDER;
        n = p + 1;
        m = p - 1;
        f = m * m;
        case (kind_reg)
            KIND_POINT:   cnt = 1;
            KIND_SEGMENT: cnt = n;
            KIND_QUAD:    cnt = n * n;
            default:      cnt = n * n * n;
        endcase
        res.oor = 1'b0;
        pos = 0;
        if (node >= cnt) begin
            res.oor = 1'b1;
        end else if (kind_reg == KIND_POINT) begin
            pos = 0;
        end else if (kind_reg == KIND_SEGMENT) begin
            if (node == 0) pos = 0;
            else if (node == p) pos = 1;
            else pos = node + 1;
        end else begin
            i = node % n;
            j = (node / n) % n;
            k = (kind_reg == KIND_QUAD) ? 0 : node / (n * n);
            ib = (i == 0 || i == p);
            jb = (j == 0 || j == p);
            kb = (k == 0 || k == p);
            if (kind_reg == KIND_QUAD) begin
                // quad: corners, then edges bottom/right/top/left, then interior
                if (ib && jb)
                    pos = (i != 0) ? ((j != 0) ? 2 : 1) : ((j != 0) ? 3 : 0);
                else if (jb)
                    pos = 4 + (i - 1) + ((j != 0) ? 2 * m : 0);
                else if (ib)
                    pos = 4 + (j - 1) + ((i != 0) ? m : 3 * m);
                else
                    pos = 4 + 4 * m + (i - 1) + m * (j - 1);
            end else begin
                // hex: classify by how many digits sit on a boundary
                nb = ib + jb + kb;
                base = 8;
                if (nb == 3) begin
                    pos = ((i != 0) ? ((j != 0) ? 2 : 1) : ((j != 0) ? 3 : 0))
                        + ((k != 0) ? 4 : 0);
                end else if (nb == 2) begin
                    if (!ib)
                        pos = base + (i - 1) + ((j != 0) ? 2 * m : 0)
                            + ((k != 0) ? 4 * m : 0);
                    else if (!jb)
                        pos = base + (j - 1) + ((i != 0) ? m : 3 * m)
                            + ((k != 0) ? 4 * m : 0);
                    else
                        pos = base + 8 * m + (k - 1)
                            + m * ((i != 0) ? ((j != 0) ? 3 : 1) : ((j != 0) ? 2 : 0));
                end else if (nb == 1) begin
                    base = base + 12 * m;
                    if (ib)
                        pos = base + (j - 1) + m * (k - 1) + ((i != 0) ? f : 0);
                    else if (jb)
                        pos = base + 2 * f + (i - 1) + m * (k - 1) + ((j != 0) ? f : 0);
                    else
                        pos = base + 4 * f + (i - 1) + m * (j - 1) + ((k != 0) ? f : 0);
                end else begin
                    pos = base + 12 * m + 6 * f + (i - 1) + m * ((j - 1) + m * (k - 1));
                end
            end
        end
        res.pos = pos[POS_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Check results, predict accepted requests, track register writes, watch for hangs
    always @(posedge i_clk) begin : monitor
        t_vtk_result want;
        bit          progress;
        progress = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) begin
                progress = 1'b1;
                if (expected_vtk_q.size() == 0) begin
                    report_mismatch("result with no request pending", 0, o_vtk_position);
                end else begin
                    want = expected_vtk_q.pop_front();
                    if (o_vtk_position !== want.pos)
                        report_mismatch("vtk_position", want.pos, o_vtk_position);
                    if (o_out_of_range !== want.oor)
                        report_mismatch("out_of_range", want.oor, o_out_of_range);
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                progress = 1'b1;
                expected_vtk_q.push_back(map_node_to_vtk(i_node_number, shadow_order,
                                                         shadow_kind));
            end
            if (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1) begin
                progress = 1'b1;
                if (i_cfg_index == REG_ELEMENT_ORDER)
                    shadow_order = i_cfg_data;
                else if (i_cfg_index == REG_GEOMETRY_KIND)
                    shadow_kind = i_cfg_data[KIND_W-1:0];
            end
        end
        if (progress) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Issue one node request and hold it until taken; then idle at random
    task automatic send_node(input logic [NODE_W-1:0] node);
        start <= 1'b1;
        i_node_number <= node;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Drop start and wait for every pending result
    task automatic settle_pipeline();
        start <= 1'b0;
        @(negedge i_clk);
        while (expected_vtk_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Write order and kind; optionally poke an unused index with junk
    task automatic apply_geometry(input logic [ORDER_W-1:0] order,
                                  input logic [KIND_W-1:0] kind, input bit poke_spare);
        logic [CFG_DATA_W-1:0] kind_data;
        kind_data = CFG_DATA_W'($urandom);
        kind_data[KIND_W-1:0] = kind;
        cfg_write(REG_ELEMENT_ORDER, order);
        cfg_write(REG_GEOMETRY_KIND, kind_data);
        if (poke_spare)
            cfg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reset state: order 1 hexahedron of eight nodes, plus node 8 just beyond it
    task automatic test_reset_defaults();
        send_node(12'd0);
        send_node(12'd3);
        send_node(12'd5);
        send_node(12'd7);
        send_node(12'd8);
        settle_pipeline();
    endtask

    // Order zero acts as order one; largest orders reach the top node number
    task automatic test_order_limits();
        apply_geometry(4'd0, KIND_HEX, 1'b0);
        send_node(12'd7);
        send_node(12'd8);
        settle_pipeline();
        apply_geometry(4'd15, KIND_HEX, 1'b0);
        send_node(12'd0);
        send_node(12'd4095);
        send_node(12'd1365);
        settle_pipeline();
        apply_geometry(4'd14, KIND_HEX, 1'b0);
        send_node(12'd3374);
        send_node(12'd3375);
        settle_pipeline();
    endtask

    // Point, segment and quad, with writes to unused indexes in between
    task automatic test_lower_kinds();
        apply_geometry(4'd9, KIND_POINT, 1'b1);
        send_node(12'd0);
        send_node(12'd1);
        settle_pipeline();
        apply_geometry(4'd15, KIND_SEGMENT, 1'b1);
        send_node(12'd0);
        send_node(12'd15);
        send_node(12'd7);
        send_node(12'd16);
        settle_pipeline();
        apply_geometry(4'd3, KIND_QUAD, 1'b1);
        send_node(12'd0);
        send_node(12'd3);
        send_node(12'd12);
        send_node(12'd15);
        send_node(12'd1);
        send_node(12'd4);
        send_node(12'd5);
        send_node(12'd16);
        settle_pipeline();
    endtask

    // Random geometries, mostly valid nodes, some beyond the element
    task automatic test_random_mapping(input int idle_pct, input int node_total);
        int                 sent, batch, p, limit, pick;
        logic [ORDER_W-1:0] order;
        logic [KIND_W-1:0]  kind;
        logic [NODE_W-1:0]  node;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < node_total) begin
            pick = $urandom_range(9);
            order = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : ORDER_W'($urandom_range(15));
            pick = $urandom_range(7);
            kind = (pick == 0) ? KIND_POINT : (pick == 1) ? KIND_SEGMENT :
                   (pick < 4) ? KIND_QUAD : KIND_HEX;
            apply_geometry(order, kind, $urandom_range(3) == 0);
            p = (order == 0) ? 1 : order;
            limit = (kind == KIND_POINT) ? 1 : (kind == KIND_SEGMENT) ? p + 1 :
                    (kind == KIND_QUAD) ? (p + 1) * (p + 1) : (p + 1) * (p + 1) * (p + 1);
            batch = $urandom_range(30, 80);
            repeat (batch) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    node = NODE_W'($urandom_range(limit - 1));
                else if (pick < 90)
                    node = NODE_W'((limit + $urandom_range(1)) - 1);
                else
                    node = NODE_W'($urandom);
                send_node(node);
            end
            sent += batch;
            settle_pipeline();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_node_number   = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        shadow_order    = ORDER_RESET;
        shadow_kind     = KIND_RESET;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        quiet_cycles    = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_order_limits();
        test_lower_kinds();
        test_random_mapping(0, PHASE_NODES);
        test_random_mapping(53, PHASE_NODES);
        test_random_mapping(28, PHASE_NODES);

        settle_pipeline();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### tensor_lagrange_vtk_node_index.f
hdl/tlvni_pkg.sv
hdl/tlvni_split.sv
hdl/tensor_lagrange_vtk_node_index.sv
dv/tb_top.sv
